[rtl/sorted_line_table_macros.svh]
// assertion macros used by the sorted line table checker
`ifndef SORTED_LINE_TABLE_MACROS_SVH
`define SORTED_LINE_TABLE_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define SLT_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define SLT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/slt_pkg.sv]
// types and constants of the sorted line table
package slt_pkg;

    localparam int LINE_W   = 16;
    localparam int HANDLE_W = 16;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 9;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [LINE_W-1:0]   line_number;
        logic                text_present;
        logic [HANDLE_W-1:0] payload_handle;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [POS_W-1:0]    entry_total;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic search_step;
        logic rd_shift;
        logic shift_init;
        logic shift_step;
        logic commit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic search_done;
        logic shift_needed;
        logic shift_last;
    } t_dp_stat;

endpackage

[rtl/slt_ctrl.sv]
// sequencing state machine of the sorted line table
module slt_ctrl
    import slt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SRCH   = 3'd1;
    localparam logic [2:0] S_CMP    = 3'd2;
    localparam logic [2:0] S_SH_RD  = 3'd3;
    localparam logic [2:0] S_SH_WR  = 3'd4;
    localparam logic [2:0] S_COMMIT = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SRCH;
                end
            end
            S_SRCH: begin
                if (!i_stat.search_done) begin
                    n_state = S_CMP;
                end else if (i_stat.shift_needed) begin
                    o_cmd.shift_init = 1'b1;
                    n_state          = S_SH_RD;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_CMP: begin
                o_cmd.search_step = 1'b1;
                n_state           = S_SRCH;
            end
            S_SH_RD: begin
                o_cmd.rd_shift = 1'b1;
                n_state        = S_SH_WR;
            end
            S_SH_WR: begin
                o_cmd.shift_step = 1'b1;
                n_state          = i_stat.shift_last ? S_COMMIT : S_SH_RD;
            end
            S_COMMIT: begin
                if (w_slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[rtl/slt_datapath.sv]
// entry memory, search bounds, shift index and result register
module slt_datapath
    import slt_pkg::*;
#(
    parameter int CAPACITY  = 256,
    parameter int KEY_WIDTH = 16
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output t_out_item o_out_item
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = KEY_WIDTH + HANDLE_W;

    // key in the upper bits, handle in the lower bits
    logic [EW-1:0]        r_mem [CAPACITY];
    logic [EW-1:0]        r_rdata;
    logic [KEY_WIDTH-1:0] r_key;
    logic [HANDLE_W-1:0]  r_hand;
    logic                 r_pres;
    logic                 r_hit;
    logic [CW-1:0]        r_lo;
    logic [CW-1:0]        r_hi;
    logic [AW-1:0]        r_idx;
    logic [CW-1:0]        r_cnt;
    logic [CW-1:0]        n_cnt;
    t_out_item            r_out_item;

    logic [CW:0]          w_mid_sum;
    logic [CW-1:0]        w_mid;
    logic [KEY_WIDTH-1:0] w_rd_key;
    logic [AW-1:0]        w_ra;
    logic [AW-1:0]        w_wa;
    logic [EW-1:0]        w_wd;
    logic                 w_we;
    logic                 w_full;
    logic                 w_del;
    logic                 w_ins;
    logic [CW-1:0]        w_idx_ext;
    logic [STATUS_W-1:0]  w_status;

    assign w_mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid     = w_mid_sum[CW:1];
    assign w_rd_key  = r_rdata[EW-1 -: KEY_WIDTH];
    assign w_idx_ext = CW'(r_idx);
    assign w_full    = (r_cnt == CW'(CAPACITY));
    assign w_del     = !r_pres && r_hit;
    assign w_ins     = r_pres && !r_hit && !w_full;

    assign o_stat.search_done  = (r_lo >= r_hi);
    assign o_stat.shift_needed = w_del ? ((r_lo + CW'(1)) < r_cnt)
                               : (w_ins ? (r_cnt > r_lo) : 1'b0);
    assign o_stat.shift_last   = r_pres ? (w_idx_ext == r_lo)
                                        : ((w_idx_ext + CW'(1)) >= r_cnt);

    assign w_ra = i_cmd.rd_shift ? r_idx : w_mid[AW-1:0];
    assign w_we = i_cmd.shift_step || (i_cmd.commit && r_pres && (r_hit || !w_full));
    assign w_wa = i_cmd.shift_step ? (r_pres ? r_idx + AW'(1) : r_idx - AW'(1))
                                   : r_lo[AW-1:0];
    assign w_wd = i_cmd.shift_step ? r_rdata : {r_key, r_hand};

    always_comb begin
        n_cnt = r_cnt;
        priority if (!r_pres && r_hit) begin
            w_status = ST_DELETED;
            n_cnt    = r_cnt - CW'(1);
        end else if (!r_pres) begin
            w_status = ST_ABSENT;
        end else if (r_hit) begin
            w_status = ST_REPLACED;
        end else if (w_full) begin
            w_status = ST_FULL;
        end else begin
            w_status = ST_INSERTED;
            n_cnt    = r_cnt + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rdata <= r_mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.commit) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_key  <= KEY_WIDTH'(i_in_item.line_number);
            r_hand <= i_in_item.payload_handle;
            r_pres <= i_in_item.text_present;
            r_hit  <= 1'b0;
            r_lo   <= '0;
            r_hi   <= r_cnt;
        end else if (i_cmd.search_step) begin
            if (w_rd_key == r_key) begin
                r_hit <= 1'b1;
                r_lo  <= w_mid;
                r_hi  <= w_mid;
            end else if (w_rd_key < r_key) begin
                r_lo <= w_mid + CW'(1);
            end else begin
                r_hi <= w_mid;
            end
        end
        if (i_cmd.shift_init) begin
            r_idx <= r_pres ? AW'(r_cnt - CW'(1)) : AW'(r_lo + CW'(1));
        end else if (i_cmd.shift_step) begin
            r_idx <= r_pres ? r_idx - AW'(1) : r_idx + AW'(1);
        end
        if (i_cmd.commit) begin
            r_out_item.status      <= w_status;
            r_out_item.position    <= POS_W'(r_lo);
            r_out_item.entry_total <= POS_W'(n_cnt);
        end
    end

    assign o_out_item = r_out_item;

endmodule

[rtl/sorted_line_table.sv]
// top level of the sorted line table: controller plus datapath
//
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_ready    i_in_item  (t_in_item)
//  out       output     o_out_valid / i_out_ready  o_out_item (t_out_item)
//
//  steps of a transaction: a state to take it, a search and a compare state per probe of
//  the binary search (at most clog2(entries + 1) probes), a search state that sees the
//  search end, a read and a write state per entry moved by the shift (worst case
//  CAPACITY - 1), and a write-back state
//  each probe and each shift step reads first because the entry memory has a registered read
//  reset clears the entry count and the handshake state only; memory needs no clearing
//  one transaction at a time; a finished result waits in the output register while
//  the next transaction is taken, and write-back stalls only if that register is still full
module sorted_line_table
    import slt_pkg::*;
#(
    parameter int CAPACITY  = 256,
    parameter int KEY_WIDTH = 16
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    // command and status between the two halves
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // state machine: search loop, shift loop, write-back and result handshake
    slt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // entry memory, binary search bounds, shift index, count and result register
    slt_datapath #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out_item (o_out_item)
    );

endmodule

[rtl/slt_checker.sv]
// port-level checker of the sorted line table, bound to the top level
`include "sorted_line_table_macros.svh"

module slt_checker
    import slt_pkg::*;
#(
    parameter int CAPACITY  = 256
)
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    localparam logic [POS_W-1:0] FULL_TOTAL = POS_W'(CAPACITY);

    logic w_in_take;
    logic w_out_stall;
    logic w_full_res;

    assign w_in_take   = i_in_valid && o_in_ready;
    assign w_out_stall = o_out_valid && !i_out_ready;
    assign w_full_res  = o_out_valid && (o_out_item.status == ST_FULL);

    // a stalled result holds
    `SLT_ASSERT_NEXT(a_out_hold, w_out_stall, o_out_valid && $stable(o_out_item), "result dropped")

    // one transaction at a time
    `SLT_ASSERT_NEXT(a_one_busy, w_in_take, !o_in_ready, "second transaction taken while busy")

    // a new result only appears as the block goes back to idle
    `SLT_ASSERT_NOW(a_done_idle, $rose(o_out_valid), o_in_ready, "result shown while busy")

    // a full report carries the full count
    `SLT_ASSERT_NOW(a_full_total, w_full_res, o_out_item.entry_total == FULL_TOTAL, "full count")

endmodule

bind sorted_line_table slt_checker #(.CAPACITY(CAPACITY)) u_slt_checker (.*);

[tb/tb_top.sv]
// testbench of the sorted line table: scripted and random line edits checked against a shadow table
`timescale 1ns / 1ps

module tb_top;
    import slt_pkg::*;

    // table size and key width are the block's defaults
    localparam int TABLE_DEPTH = 256;
    localparam int POOL_SIZE   = 40;
    // one long receiver hold-off, well past what two transactions need
    localparam int HOLD_CYCLES = 3000;
    // worst case of one transaction: full shift plus search and write-back
    localparam int TAIL_CYCLES = 2 * TABLE_DEPTH + 80;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    // one row of the scripted part: the edit and, where obvious, the outcome typed in
    typedef struct {
        t_in_item  req;
        bit        checked;
        t_out_item want;
    } t_script_row;

    // shadow copy of the table, kept in step with accepted transactions
    logic [LINE_W-1:0]   shadow_keys    [TABLE_DEPTH];
    logic [HANDLE_W-1:0] shadow_handles [TABLE_DEPTH];
    int unsigned         shadow_count;

    // outcomes still owed by the block, oldest first
    t_out_item result_due_q[$];
    int        fault_count;

    // typed-in outcome travelling with the offered transaction
    bit        offer_checked;
    t_out_item offer_want;

    // shared pacing controls
    bit steady;       // no idling on either side
    bit rx_hold_req;  // ask the receiver for one long hold-off

    sorted_line_table #(
        .CAPACITY  (TABLE_DEPTH),
        .KEY_WIDTH (LINE_W)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // binary search over the occupied entries, then delete, replace, insert or refuse
    function automatic t_out_item apply_line_edit(input t_in_item req);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned pos;
        int unsigned i;
        bit          hit;
        t_out_item   res;
        lo  = 0;
        hi  = shadow_count;
        mid = 0;
        hit = 1'b0;
        while (lo < hi && !hit) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_keys[mid] == req.line_number)
                hit = 1'b1;
            else if (shadow_keys[mid] < req.line_number)
                lo = mid + 1;
            else
                hi = mid;
        end
        pos = hit ? mid : lo;
        if (!req.text_present) begin
            if (hit) begin
                // close the gap: later entries move down one place
                for (i = pos; i + 1 < shadow_count; i++) begin
                    shadow_keys[i]    = shadow_keys[i + 1];
                    shadow_handles[i] = shadow_handles[i + 1];
                end
                shadow_count--;
                res.status = ST_DELETED;
            end else begin
                res.status = ST_ABSENT;
            end
        end else if (hit) begin
            shadow_handles[pos] = req.payload_handle;
            res.status = ST_REPLACED;
        end else if (shadow_count >= TABLE_DEPTH) begin
            res.status = ST_FULL;
        end else begin
            // open a gap: entries from the insertion point move up one place
            for (i = shadow_count; i > pos; i--) begin
                shadow_keys[i]    = shadow_keys[i - 1];
                shadow_handles[i] = shadow_handles[i - 1];
            end
            shadow_keys[pos]    = req.line_number;
            shadow_handles[pos] = req.payload_handle;
            shadow_count++;
            res.status = ST_INSERTED;
        end
        res.position    = POS_W'(pos);
        res.entry_total = POS_W'(shadow_count);
        return res;
    endfunction

    function automatic t_in_item line_edit(input logic [LINE_W-1:0] key, input logic present,
                                           input logic [HANDLE_W-1:0] handle);
        t_in_item req;
        req.line_number    = key;
        req.text_present   = present;
        req.payload_handle = handle;
        return req;
    endfunction

    // a key that is in the table now, or a random one when it is empty
    function automatic logic [LINE_W-1:0] stored_key();
        if (shadow_count == 0)
            return LINE_W'($urandom);
        return shadow_keys[$urandom_range(shadow_count - 1)];
    endfunction

    // offer one transaction, at times after a random gap unless steady, and hold it until taken
    task automatic push_line(input t_in_item req, input bit checked, input t_out_item want);
        if (!steady && $urandom_range(99) < 27) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_in_item     <= req;
        offer_checked <= checked;
        offer_want    <= want;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // scoreboard: results are retired before the new transaction is predicted
    always @(posedge i_clk) begin
        t_out_item due;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (result_due_q.size() == 0) begin
                    fault_count++;
                    $display("%0t: unexpected result, expected none, actual %p",
                             $time, o_out_item);
                end else begin
                    due = result_due_q.pop_front();
                    if (o_out_item.status !== due.status) begin
                        fault_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, due.status, o_out_item.status);
                    end
                    if (o_out_item.position !== due.position) begin
                        fault_count++;
                        $display("%0t: position expected %0d actual %0d",
                                 $time, due.position, o_out_item.position);
                    end
                    if (o_out_item.entry_total !== due.entry_total) begin
                        fault_count++;
                        $display("%0t: entry_total expected %0d actual %0d",
                                 $time, due.entry_total, o_out_item.entry_total);
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                // the shadow table always advances; a typed-in outcome takes precedence
                due = apply_line_edit(i_in_item);
                result_due_q.push_back(offer_checked ? offer_want : due);
            end
        end
    end

    // receiver: random back-pressure, a steady stretch, and one long hold-off on request
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else if (steady) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= 27);
            end
        end
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #32_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // stimulus
    initial begin
        t_script_row         script[$];
        logic [LINE_W-1:0]   key_pool [POOL_SIZE];
        t_out_item           no_want;
        int unsigned         n;
        int unsigned         r;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_in_item     <= '0;
        offer_checked <= 1'b0;
        offer_want    <= '0;
        steady        = 1'b0;
        rx_hold_req   = 1'b0;
        fault_count   = 0;
        shadow_count  = 0;
        no_want       = '0;

        // scripted part: empty table, key and handle extremes, every outcome bar the full one
        script.push_back('{line_edit(16'd100, 1'b0, 16'h0000), 1'b1, '{ST_ABSENT, 9'd0, 9'd0}});
        script.push_back('{line_edit(16'h0000, 1'b1, 16'h0000), 1'b1, '{ST_INSERTED, 9'd0, 9'd1}});
        script.push_back('{line_edit(16'hffff, 1'b1, 16'hffff), 1'b1, '{ST_INSERTED, 9'd1, 9'd2}});
        script.push_back('{line_edit(16'h0000, 1'b1, 16'hffff), 1'b1, '{ST_REPLACED, 9'd0, 9'd2}});
        script.push_back('{line_edit(16'hffff, 1'b1, 16'h0000), 1'b1, '{ST_REPLACED, 9'd1, 9'd2}});
        script.push_back('{line_edit(16'h8000, 1'b1, 16'h5a5a), 1'b0, no_want});
        script.push_back('{line_edit(16'h7fff, 1'b1, 16'ha5a5), 1'b0, no_want});
        script.push_back('{line_edit(16'h0001, 1'b1, 16'h1234), 1'b0, no_want});
        script.push_back('{line_edit(16'hfffe, 1'b1, 16'h8001), 1'b0, no_want});
        // delete in the middle, then the same key again as a miss
        script.push_back('{line_edit(16'h7fff, 1'b0, 16'hffff), 1'b0, no_want});
        script.push_back('{line_edit(16'h7fff, 1'b0, 16'h0000), 1'b0, no_want});
        script.push_back('{line_edit(16'h0000, 1'b0, 16'h0000), 1'b1, '{ST_DELETED, 9'd0, 9'd4}});
        script.push_back('{line_edit(16'hffff, 1'b0, 16'h0000), 1'b0, no_want});
        script.push_back('{line_edit(16'h0001, 1'b1, 16'hffff), 1'b0, no_want});
        script.push_back('{line_edit(16'h0002, 1'b0, 16'h0000), 1'b0, no_want});
        script.push_back('{line_edit(16'h4000, 1'b1, 16'h0f0f), 1'b0, no_want});
        script.push_back('{line_edit(16'h0001, 1'b0, 16'h0000), 1'b0, no_want});
        script.push_back('{line_edit(16'h8000, 1'b0, 16'h0000), 1'b0, no_want});
        script.push_back('{line_edit(16'hfffe, 1'b0, 16'h0000), 1'b0, no_want});
        // last entry goes, then the empty table again
        script.push_back('{line_edit(16'h4000, 1'b0, 16'h0000), 1'b1, '{ST_DELETED, 9'd0, 9'd0}});
        script.push_back('{line_edit(16'h0000, 1'b0, 16'h0000), 1'b1, '{ST_ABSENT, 9'd0, 9'd0}});
        script.push_back('{line_edit(16'h1234, 1'b1, 16'h0000), 1'b1, '{ST_INSERTED, 9'd0, 9'd1}});
        script.push_back('{line_edit(16'h1234, 1'b0, 16'h0000), 1'b1, '{ST_DELETED, 9'd0, 9'd0}});

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i])
            push_line(script[i].req, script[i].checked, script[i].want);

        // churn over a small pool of full-width keys: many hits, replaces and deletes
        foreach (key_pool[i])
            key_pool[i] = LINE_W'($urandom);
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (n = 0; n < 300; n++) begin
            if (n == 80)
                rx_hold_req = 1'b1;  // receiver stalls while we keep offering
            if (n == 160) begin
                // sender pause until the block has nothing outstanding
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (result_due_q.size() != 0) @(posedge i_clk);
            end
            steady = (n >= 220 && n < 290);
            push_line(line_edit(key_pool[$urandom_range(POOL_SIZE - 1)],
                                $urandom_range(99) < 60, HANDLE_W'($urandom)),
                      1'b0, no_want);
        end
        steady = 1'b0;

        // fill to capacity, mostly fresh keys with some replaces and deletes
        n = 0;
        while (shadow_count < TABLE_DEPTH && n < 2000) begin
            r = $urandom_range(99);
            if (r < 85)
                push_line(line_edit(LINE_W'($urandom), 1'b1, HANDLE_W'($urandom)), 1'b0, no_want);
            else if (r < 93)
                push_line(line_edit(stored_key(), 1'b1, HANDLE_W'($urandom)), 1'b0, no_want);
            else
                push_line(line_edit(stored_key(), 1'b0, HANDLE_W'($urandom)), 1'b0, no_want);
            n++;
        end

        // around the full mark: refused inserts, replaces, deletes that free a slot
        for (n = 0; n < 60; n++) begin
            r = $urandom_range(99);
            if (r < 50)
                push_line(line_edit(LINE_W'($urandom), 1'b1, HANDLE_W'($urandom)), 1'b0, no_want);
            else if (r < 75)
                push_line(line_edit(stored_key(), 1'b1, HANDLE_W'($urandom)), 1'b0, no_want);
            else if (r < 90)
                push_line(line_edit(stored_key(), 1'b0, HANDLE_W'($urandom)), 1'b0, no_want);
            else
                push_line(line_edit(LINE_W'($urandom), 1'b0, HANDLE_W'($urandom)), 1'b0, no_want);
        end

        // drain back to empty, with misses and the odd insert mixed in
        n = 0;
        while (shadow_count > 0 && n < 3000) begin
            r = $urandom_range(99);
            if (r < 75)
                push_line(line_edit(stored_key(), 1'b0, HANDLE_W'($urandom)), 1'b0, no_want);
            else if (r < 90)
                push_line(line_edit(LINE_W'($urandom), 1'b0, HANDLE_W'($urandom)), 1'b0, no_want);
            else
                push_line(line_edit(LINE_W'($urandom), 1'b1, HANDLE_W'($urandom)), 1'b0, no_want);
            n++;
        end
        for (n = 0; n < 4; n++)
            push_line(line_edit(LINE_W'($urandom), 1'b0, HANDLE_W'($urandom)), 1'b0, no_want);

        // wind down: everything owed must arrive, then a quiet tail for strays
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (result_due_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && result_due_q.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/slt_pkg.sv
rtl/slt_ctrl.sv
rtl/slt_datapath.sv
rtl/sorted_line_table.sv
rtl/slt_checker.sv
tb/tb_top.sv
